// ===== rtl/core/fpcu_pkg.sv =====
// Package for the fly camera update core: fixed-point constants and the
// CORDIC arctangent table. No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package fpcu_pkg;
    localparam int unsigned FULL_TURN    = 46080;
    localparam int unsigned HALF_TURN    = 23040;
    localparam int unsigned QUARTER_TURN = 11520;
    localparam int          PITCH_LIMIT  = 11392;
    localparam int          ONE_Q14      = 16384;
    localparam int          TABLE_LEN    = 24;
    localparam logic [33:0] CORDIC_X0    = 34'd652032874;

    function automatic logic [21:0] atan_entry(input logic [4:0] i);
        logic [21:0] v;
        begin
            case (i)
                5'd0:  v = 22'd1474560;
                5'd1:  v = 22'd870484;
                5'd2:  v = 22'd459940;
                5'd3:  v = 22'd233473;
                5'd4:  v = 22'd117189;
                5'd5:  v = 22'd58652;
                5'd6:  v = 22'd29333;
                5'd7:  v = 22'd14667;
                5'd8:  v = 22'd7334;
                5'd9:  v = 22'd3667;
                5'd10: v = 22'd1833;
                5'd11: v = 22'd917;
                5'd12: v = 22'd458;
                5'd13: v = 22'd229;
                5'd14: v = 22'd115;
                5'd15: v = 22'd57;
                5'd16: v = 22'd29;
                5'd17: v = 22'd14;
                5'd18: v = 22'd7;
                5'd19: v = 22'd4;
                5'd20: v = 22'd2;
                5'd21: v = 22'd1;
                default: v = 22'd0;
            endcase
            return v;
        end
    endfunction
endpackage
`default_nettype wire

// ===== rtl/core/fpcu_if.sv =====
// Valid/ready channel interfaces for the fly camera update core.
// Depends on nothing.
`timescale 1ns / 1ps
`default_nettype none
interface fpcu_in_if;
    logic              valid;
    logic              ready;
    logic [3:0]        key_mask;
    logic              look_held;
    logic signed [11:0] mouse_dx;
    logic signed [11:0] mouse_dy;
    logic [15:0]       time_step;
    modport source (output valid, key_mask, look_held, mouse_dx, mouse_dy, time_step,
                    input ready);
    modport sink   (input valid, key_mask, look_held, mouse_dx, mouse_dy, time_step,
                    output ready);
endinterface

interface fpcu_out_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_z;
    logic signed [15:0] look_x;
    logic signed [15:0] look_y;
    logic signed [15:0] look_z;
    logic [15:0]        yaw_angle;
    logic signed [14:0] pitch_angle;
    modport source (output valid, pos_x, pos_y, pos_z, look_x, look_y, look_z,
                    yaw_angle, pitch_angle, input ready);
    modport sink   (input valid, pos_x, pos_y, pos_z, look_x, look_y, look_z,
                    yaw_angle, pitch_angle, output ready);
endinterface

interface fpcu_cfg_if;
    logic        valid;
    logic        ready;
    logic [15:0] move_speed;
    modport source (output valid, move_speed, input ready);
    modport sink   (input valid, move_speed, output ready);
endinterface
`default_nettype wire

// ===== rtl/core/first_person_camera_update_core.sv =====
// Fly camera update core: one frame tick in, one camera state out.
// Depends on fpcu_pkg and the channel interfaces in fpcu_if.sv.
//
// Channels: in_ch carries one frame tick (keys, look button, mouse deltas,
// frame time); out_ch returns position, look vector, yaw and pitch after the
// tick; cfg_ch writes move_speed (unsigned Q8.8), taken in any cycle.
// The block works on one tick at a time: in_ch.ready is low from acceptance
// until the result register has been loaded. One CORDIC rotator serves yaw
// then pitch, and one multiplier serves the look products, the speed scale
// and all three position steps. The result sits in an output register; while
// the receiver stalls it holds, and a new tick may be accepted and computed
// behind it, but its result waits until the register is free.
// Reset clears yaw, pitch and position to zero and move_speed to 1.0.
`timescale 1ns / 1ps
`default_nettype none
module first_person_camera_update_core #(
    parameter int CORDIC_STEPS = 16,
    parameter int POS_BITS     = 32
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    fpcu_in_if.sink     in_ch,
    fpcu_out_if.source  out_ch,
    fpcu_cfg_if.sink    cfg_ch
);
    import fpcu_pkg::*;

    localparam int NSTEP = (CORDIC_STEPS < TABLE_LEN) ? CORDIC_STEPS : TABLE_LEN;
    localparam int IW    = $clog2(TABLE_LEN + 1);

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_TURN  = 4'd1;
    localparam logic [3:0] S_PREP  = 4'd2;
    localparam logic [3:0] S_ROT   = 4'd3;
    localparam logic [3:0] S_FIN   = 4'd4;
    localparam logic [3:0] S_MUL   = 4'd5;
    localparam logic [3:0] S_SCALE = 4'd6;
    localparam logic [3:0] S_AX    = 4'd7;
    localparam logic [3:0] S_OUT   = 4'd8;

    logic [3:0]  r_state;
    logic [15:0] r_speed;
    logic [3:0]  r_keys;
    logic        r_held;
    logic signed [11:0] r_dx, r_dy;
    logic [15:0] r_dt;
    logic [15:0] r_yaw;
    logic signed [14:0] r_pitch;
    logic signed [POS_BITS-1:0] r_px, r_py, r_pz;
    logic        r_which;
    logic [IW-1:0] r_i;
    logic signed [33:0] r_x, r_y;
    logic signed [22:0] r_z;
    logic        r_neg;
    logic signed [15:0] r_sy, r_cy, r_sp, r_cp;
    logic signed [15:0] r_lx, r_lz;
    logic [1:0]  r_step;
    logic [31:0] r_scale;
    logic signed [POS_BITS-1:0] r_ox, r_oy, r_oz;
    logic signed [15:0] r_olx, r_oly, r_olz;
    logic [15:0] r_oyaw;
    logic signed [14:0] r_opitch;
    logic        r_ovalid;

    // turn
    logic signed [19:0] w_t, w_t2;
    logic signed [19:0] w_p;
    logic signed [17:0] w_r;
    logic               w_neg;
    logic signed [33:0] w_dx, w_dy;
    logic [21:0]        w_at;
    logic signed [16:0] w_xr, w_yr;
    logic signed [15:0] w_xc, w_yc;
    // shared multiplier
    logic signed [17:0] w_ma;
    logic signed [33:0] w_mb;
    logic signed [51:0] w_prod;
    logic signed [15:0] w_mq;
    // axis step
    logic signed [1:0]  w_fwd, w_str;
    logic signed [15:0] w_rc, w_lc;
    logic signed [17:0] w_comb;
    logic signed [51:0] w_d;
    logic signed [POS_BITS+20:0] w_sum;
    logic signed [POS_BITS-1:0]  w_pin, w_pnew;
    logic signed [POS_BITS+20:0] w_lim_hi, w_lim_lo;

    assign in_ch.ready  = (r_state == S_IDLE);
    assign cfg_ch.ready = 1'b1;
    assign out_ch.valid = r_ovalid;
    assign out_ch.pos_x = 32'(r_ox);
    assign out_ch.pos_y = 32'(r_oy);
    assign out_ch.pos_z = 32'(r_oz);
    assign out_ch.look_x = r_olx;
    assign out_ch.look_y = r_oly;
    assign out_ch.look_z = r_olz;
    assign out_ch.yaw_angle = r_oyaw;
    assign out_ch.pitch_angle = r_opitch;

    always_comb begin
        w_t  = 20'(signed'({4'b0000, r_yaw})) - 20'(r_dx) * 20'sd64;
        w_t2 = w_t + 20'(3 * FULL_TURN);
        if (w_t2 >= 20'(4 * FULL_TURN)) begin
            w_t2 = w_t2 - 20'(4 * FULL_TURN);
        end
        if (w_t2 >= 20'(2 * FULL_TURN)) begin
            w_t2 = w_t2 - 20'(2 * FULL_TURN);
        end
        if (w_t2 >= 20'(FULL_TURN)) begin
            w_t2 = w_t2 - 20'(FULL_TURN);
        end
        w_p  = 20'(r_pitch) - 20'(r_dy) * 20'sd64;

        if (r_which) begin
            w_r = (r_pitch < 0) ? 18'(r_pitch) + 18'(FULL_TURN) : 18'(r_pitch);
        end else begin
            w_r = (r_yaw >= 16'(HALF_TURN)) ? 18'(r_yaw) - 18'(HALF_TURN)
                                            : 18'(r_yaw) + 18'(HALF_TURN);
        end
        w_neg = 1'b0;
        if (w_r >= 18'(FULL_TURN - QUARTER_TURN)) begin
            w_r = w_r - 18'(FULL_TURN);
        end else if (w_r > 18'(QUARTER_TURN)) begin
            w_r = w_r - 18'(HALF_TURN);
            w_neg = 1'b1;
        end

        w_dx = r_y >>> r_i;
        w_dy = r_x >>> r_i;
        w_at = atan_entry(5'(r_i));

        w_xr = 17'((r_x + 34'sd32768) >>> 16);
        w_yr = 17'((r_y + 34'sd32768) >>> 16);
        w_xc = (w_xr > 17'(ONE_Q14)) ? 16'(ONE_Q14)
             : ((w_xr < -17'(ONE_Q14)) ? -16'(ONE_Q14) : 16'(w_xr));
        w_yc = (w_yr > 17'(ONE_Q14)) ? 16'(ONE_Q14)
             : ((w_yr < -17'(ONE_Q14)) ? -16'(ONE_Q14) : 16'(w_yr));

        w_fwd = 2'(signed'({1'b0, r_keys[0]})) - 2'(signed'({1'b0, r_keys[1]}));
        w_str = 2'(signed'({1'b0, r_keys[3]})) - 2'(signed'({1'b0, r_keys[2]}));
        case (r_step)
            2'd0: begin w_rc = -r_cy; w_lc = r_lx; w_pin = r_px; end
            2'd1: begin w_rc = '0;    w_lc = r_sp; w_pin = r_py; end
            default: begin w_rc = r_sy; w_lc = r_lz; w_pin = r_pz; end
        endcase
        w_comb = 18'(w_rc) * 18'(w_str) + 18'(w_lc) * 18'(w_fwd);

        case (r_state)
            S_MUL:   begin w_ma = 18'(r_step[0] ? r_cy : r_sy); w_mb = 34'(r_cp); end
            S_SCALE: begin w_ma = 18'(signed'({2'b00, r_speed})); w_mb = 34'(r_dt); end
            default: begin w_ma = w_comb; w_mb = 34'(signed'({2'b00, r_scale})); end
        endcase
        w_prod = 52'(w_ma) * 52'(w_mb);
        w_mq   = 16'((w_prod + 52'sd8192) >>> 14);
        w_d    = (w_prod + 52'sd2097152) >>> 22;
        w_sum  = (POS_BITS+21)'(w_pin) + (POS_BITS+21)'(w_d);
        w_lim_hi = (POS_BITS+21)'({1'b0, {(POS_BITS-1){1'b1}}});
        w_lim_lo = -w_lim_hi - 1;
        w_pnew = (w_sum > w_lim_hi) ? POS_BITS'(w_lim_hi)
               : ((w_sum < w_lim_lo) ? POS_BITS'(w_lim_lo) : POS_BITS'(w_sum));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_speed  <= 16'd256;
            r_yaw    <= '0;
            r_pitch  <= '0;
            r_px     <= '0;
            r_py     <= '0;
            r_pz     <= '0;
            r_ovalid <= 1'b0;
        end else begin
            if (cfg_ch.valid) begin
                r_speed <= cfg_ch.move_speed;
            end
            if (r_state == S_OUT && (!r_ovalid || out_ch.ready)) begin
                r_ovalid <= 1'b1;
            end else if (out_ch.ready) begin
                r_ovalid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (in_ch.valid) begin
                        r_keys  <= in_ch.key_mask;
                        r_held  <= in_ch.look_held;
                        r_dx    <= in_ch.mouse_dx;
                        r_dy    <= in_ch.mouse_dy;
                        r_dt    <= in_ch.time_step;
                        r_state <= S_TURN;
                    end
                end
                S_TURN: begin
                    if (r_held) begin
                        r_yaw   <= 16'(w_t2);
                        r_pitch <= (w_p > 20'(PITCH_LIMIT)) ? 15'(PITCH_LIMIT)
                                 : ((w_p < -20'(PITCH_LIMIT)) ? -15'(PITCH_LIMIT)
                                                             : 15'(w_p));
                    end
                    r_which <= 1'b0;
                    r_state <= S_PREP;
                end
                S_PREP: begin
                    r_x     <= signed'(CORDIC_X0);
                    r_y     <= '0;
                    r_z     <= 23'(w_r) * 23'sd256;
                    r_neg   <= w_neg;
                    r_i     <= '0;
                    r_state <= S_ROT;
                end
                S_ROT: begin
                    if (r_z >= 0) begin
                        r_x <= r_x - w_dx;
                        r_y <= r_y + w_dy;
                        r_z <= r_z - 23'(w_at);
                    end else begin
                        r_x <= r_x + w_dx;
                        r_y <= r_y - w_dy;
                        r_z <= r_z + 23'(w_at);
                    end
                    r_i <= r_i + IW'(1);
                    if (r_i == IW'(NSTEP - 1)) begin
                        r_state <= S_FIN;
                    end
                end
                S_FIN: begin
                    if (!r_which) begin
                        r_cy    <= r_neg ? -w_xc : w_xc;
                        r_sy    <= r_neg ? -w_yc : w_yc;
                        r_which <= 1'b1;
                        r_state <= S_PREP;
                    end else begin
                        r_cp    <= r_neg ? -w_xc : w_xc;
                        r_sp    <= r_neg ? -w_yc : w_yc;
                        r_step  <= 2'd0;
                        r_state <= S_MUL;
                    end
                end
                S_MUL: begin
                    if (r_step == 2'd0) begin
                        r_lx   <= w_mq;
                        r_step <= 2'd1;
                    end else begin
                        r_lz    <= w_mq;
                        r_state <= S_SCALE;
                    end
                end
                S_SCALE: begin
                    r_scale <= 32'(w_prod);
                    r_step  <= 2'd0;
                    r_state <= S_AX;
                end
                S_AX: begin
                    case (r_step)
                        2'd0: r_px <= w_pnew;
                        2'd1: r_py <= w_pnew;
                        default: r_pz <= w_pnew;
                    endcase
                    if (r_step == 2'd2) begin
                        r_state <= S_OUT;
                    end else begin
                        r_step <= r_step + 2'd1;
                    end
                end
                S_OUT: begin
                    if (!r_ovalid || out_ch.ready) begin
                        r_ox     <= r_px;
                        r_oy     <= r_py;
                        r_oz     <= r_pz;
                        r_olx    <= r_lx;
                        r_oly    <= r_sp;
                        r_olz    <= r_lz;
                        r_oyaw   <= r_yaw;
                        r_opitch <= r_pitch;
                        r_state  <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end
endmodule
`default_nettype wire
